### design/pgl_pkg.sv
// pgl_pkg: shared types and constants of the priority gate linearizer
// no dependencies; imported by cfg regs, element store, request interface, top level
`timescale 1ns / 1ps
`default_nettype none

package pgl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ROW_W    = 4;
    localparam int CHAN_W   = 4;
    localparam int MODES_W  = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_MODES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR  = 2'd2;

    // reset values: 0.1 V and 1 V at 2048 codes per volt
    localparam logic signed [SAMPLE_W-1:0] LOW_THR_RST  = 16'sd205;
    localparam logic signed [SAMPLE_W-1:0] HIGH_THR_RST = 16'sd2048;

    // row modes
    localparam logic [1:0] MODE_LINEAR    = 2'd0;
    localparam logic [1:0] MODE_ALL       = 2'd1;
    localparam logic [1:0] MODE_NB_LINEAR = 2'd2;
    localparam logic [1:0] MODE_NEW_ALL   = 2'd3;

    typedef struct packed {
        logic [MODES_W-1:0]         row_modes;
        logic signed [SAMPLE_W-1:0] low_thr;
        logic signed [SAMPLE_W-1:0] high_thr;
    } t_cfg;

    // per-element stored state
    typedef struct packed {
        logic level;
        logic gate;
    } t_elem;

endpackage

`default_nettype wire

### design/pgl_in_if.sv
// pgl_in_if: request channel carrying one trigger element
// depends on pgl_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface pgl_in_if;
    import pgl_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       frame_start;
    logic                       clock_connected;
    logic signed [SAMPLE_W-1:0] clock_sample;
    logic [ROW_W-1:0]           row;
    logic [CHAN_W-1:0]          channel;
    logic                       channel_new;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       mute_in;
    logic                       mute_out;

    modport source (
        output valid, frame_start, clock_connected, clock_sample, row, channel,
               channel_new, sample, mute_in, mute_out,
        input  ready
    );

    modport sink (
        input  valid, frame_start, clock_connected, clock_sample, row, channel,
               channel_new, sample, mute_in, mute_out,
        output ready
    );
endinterface

`default_nettype wire

### design/pgl_out_if.sv
// pgl_out_if: result channel carrying one gate bit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface pgl_out_if;
    logic valid;
    logic ready;
    logic gate;

    modport source (
        output valid, gate,
        input  ready
    );

    modport sink (
        input  valid, gate,
        output ready
    );
endinterface

`default_nettype wire

### design/priority_gate_linearizer.sv
// priority_gate_linearizer: top level, two-stage read-modify-write pipeline on the element store
// depends on pgl_pkg, pgl_in_if, pgl_out_if, pgl_cfg_regs, pgl_elem_mem
// usage
//   i_req carries one trigger element per request, in frame order (row by row,
//   channel by channel); frame_start marks the first element of a frame.
//   o_rsp returns exactly one gate bit per request, in request order.
//   the config port (i_cfg_we / i_cfg_idx / i_cfg_data) writes row modes and
//   the two comparator thresholds; write only while no request is in flight.
// throughput and pipeline
//   one request per cycle sustained while o_rsp is taken. the store is read at the
//   accepting edge; the evaluate stage then evaluates, writes back and loads the
//   result register, from which o_rsp delivers the gate.
//   back-to-back requests to one element use forwarding, so there are no bubbles.
// reset
//   synchronous, active low. block flag, clock comparator and frame enable
//   clear; the store's per-entry valid bits clear at once, so every element
//   reads as level 0 / gate 0 until written. no clearing sweep is needed.
// stall
//   when o_rsp is not taken the result register holds; a full evaluate stage
//   holds its request, and i_req.ready drops until the result moves on.
`timescale 1ns / 1ps
`default_nettype none

module priority_gate_linearizer #(
    parameter int ROWS     = 9,
    parameter int CHANNELS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    pgl_in_if.sink                              i_req,
    pgl_out_if.source                           o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [pgl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pgl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pgl_pkg::*;

    localparam int ELEMS = ROWS * CHANNELS;
    localparam int IDX_W = (ELEMS > 1) ? $clog2(ELEMS) : 1;

    typedef struct packed {
        logic lvl;
        logic rise;
        logic fall;
    } t_hyst;

    // comparator checks only the threshold belonging to its current level
    function automatic t_hyst hyst(input logic lvl, input logic signed [SAMPLE_W-1:0] x,
                                   input logic signed [SAMPLE_W-1:0] lo,
                                   input logic signed [SAMPLE_W-1:0] hi);
        t_hyst h;
        h.lvl  = lvl;
        h.rise = 1'b0;
        h.fall = 1'b0;
        if (lvl) begin
            if (x <= lo) begin
                h.lvl  = 1'b0;
                h.fall = 1'b1;
            end
        end else if (x >= hi) begin
            h.lvl  = 1'b1;
            h.rise = 1'b1;
        end
        return h;
    endfunction

    t_cfg cfg;

    // handshake
    logic in_fire;
    logic s1_go;

    // read address of the incoming request
    logic [7:0]       idx_full;
    logic [IDX_W-1:0] rd_idx;
    logic             in_range;

    // evaluate stage registers
    logic                       r_s1_vld;
    logic                       r_s1_fs;
    logic                       r_s1_clk_conn;
    logic signed [SAMPLE_W-1:0] r_s1_clk;
    logic [ROW_W-1:0]           r_s1_row;
    logic                       r_s1_new;
    logic signed [SAMPLE_W-1:0] r_s1_x;
    logic                       r_s1_mute_in;
    logic                       r_s1_mute_out;
    logic                       r_s1_in_range;
    logic [IDX_W-1:0]           r_s1_idx;

    // forwarding of the write that coincided with this request's read
    logic  r_fwd_hit;
    t_elem r_fwd_data;

    // frame state
    logic r_block_flag, n_block_flag;
    logic r_clock_level, n_clock_level;
    logic r_frame_en, n_frame_en;

    // result register
    logic r_out_vld;
    logic r_out_gate;

    // evaluate stage datapath
    t_elem       mem_rd;
    t_elem       cur;
    t_elem       wr_data;
    logic        wr_en;
    logic [31:0] modes_ext;
    logic [1:0]  mode;
    logic        blk;
    t_hyst       clk_h;
    t_hyst       el_h;
    logic        g_res;

    pgl_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pgl_elem_mem #(
        .DEPTH (ELEMS),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_idx  (rd_idx),
        .o_rd_data (mem_rd),
        .i_wr_en   (wr_en),
        .i_wr_idx  (r_s1_idx),
        .i_wr_data (wr_data)
    );

    // evaluate stage advances when the result register is free or draining
    assign s1_go       = r_s1_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_s1_vld || s1_go;
    assign in_fire     = i_req.valid && i_req.ready;

    // flat element index, row major
    assign idx_full = 8'(i_req.row) * 8'(CHANNELS) + 8'(i_req.channel);
    assign rd_idx   = idx_full[IDX_W-1:0];
    assign in_range = ({1'b0, i_req.row} < 5'(ROWS)) && ({1'b0, i_req.channel} < 5'(CHANNELS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_vld  <= 1'b1;
                // write lands at the same edge as the read, so the read sees old data
                r_fwd_hit <= wr_en && (r_s1_idx == rd_idx);
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_fs       <= i_req.frame_start;
            r_s1_clk_conn <= i_req.clock_connected;
            r_s1_clk      <= i_req.clock_sample;
            r_s1_row      <= i_req.row;
            r_s1_new      <= i_req.channel_new;
            r_s1_x        <= i_req.sample;
            r_s1_mute_in  <= i_req.mute_in;
            r_s1_mute_out <= i_req.mute_out;
            r_s1_in_range <= in_range;
            r_s1_idx      <= rd_idx;
            r_fwd_data    <= wr_data;
        end
    end

    // row mode, rows beyond the register read linear
    assign modes_ext = 32'(cfg.row_modes);
    assign mode      = modes_ext[{r_s1_row, 1'b0} +: 2];

    // element state in, with new channels starting cleared
    always_comb begin
        cur = r_fwd_hit ? r_fwd_data : mem_rd;
        if (r_s1_new) begin
            cur = '0;
        end

        // frame start: clear block flag, decide frame enable
        blk           = r_block_flag;
        n_clock_level = r_clock_level;
        n_frame_en    = r_frame_en;
        clk_h         = hyst(r_clock_level, r_s1_clk, cfg.low_thr, cfg.high_thr);
        if (r_s1_fs) begin
            blk = 1'b0;
            if (!r_s1_clk_conn) begin
                n_frame_en = 1'b1;
            end else begin
                n_clock_level = clk_h.lvl;
                n_frame_en    = clk_h.rise;
            end
        end

        // element comparator and priority gating
        wr_data      = cur;
        n_block_flag = blk;
        el_h         = hyst(cur.level, r_s1_x, cfg.low_thr, cfg.high_thr);
        if (n_frame_en && r_s1_in_range) begin
            wr_data.level = el_h.lvl;
            if (el_h.rise) begin
                wr_data.gate = ((mode == MODE_ALL) || (mode == MODE_NEW_ALL) || !blk)
                               && !r_s1_mute_in;
                case (mode)
                    MODE_NEW_ALL:   n_block_flag = wr_data.gate;
                    MODE_NB_LINEAR: n_block_flag = blk;
                    default:        n_block_flag = blk || wr_data.gate;
                endcase
            end else if (el_h.fall) begin
                wr_data.gate = 1'b0;
            end
        end

        wr_en = s1_go && r_s1_in_range;
        g_res = r_s1_in_range && wr_data.gate && !r_s1_mute_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_flag  <= 1'b0;
            r_clock_level <= 1'b0;
            r_frame_en    <= 1'b0;
        end else if (s1_go) begin
            r_block_flag  <= n_block_flag;
            r_clock_level <= n_clock_level;
            r_frame_en    <= n_frame_en;
        end
    end

    // result register, parts the evaluate stage from the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_gate <= g_res;
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.gate  = r_out_gate;

`ifndef SYNTHESIS
    // a request can only enter a busy evaluate stage while it moves on
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_s1_vld) |-> s1_go)
        else $error("request accepted over a stalled evaluate stage");

    // output mute always forces the delivered gate low
    a_mute_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_mute_out) |=> (o_rsp.valid && !o_rsp.gate))
        else $error("muted element produced an open gate");

    // with no clock connected a frame start always enables the frame
    a_free_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_fs && !r_s1_clk_conn) |=> r_frame_en)
        else $error("unclocked frame not enabled");

    // non-blocking linear row at frame start leaves the block flag clear
    a_nb_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_fs && (mode == MODE_NB_LINEAR)) |=> !r_block_flag)
        else $error("non-blocking row set the block flag");
`endif

endmodule

`default_nettype wire

### design/pgl_cfg_regs.sv
// pgl_cfg_regs: row mode and comparator threshold registers
// depends on pgl_pkg
`timescale 1ns / 1ps
`default_nettype none

module pgl_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pgl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pgl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output pgl_pkg::t_cfg                         o_cfg
);
    import pgl_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_modes <= '0;
            r_cfg.low_thr   <= LOW_THR_RST;
            r_cfg.high_thr  <= HIGH_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROW_MODES: r_cfg.row_modes <= i_cfg_data[MODES_W-1:0];
                CFG_LOW_THR:   r_cfg.low_thr   <= i_cfg_data[SAMPLE_W-1:0];
                CFG_HIGH_THR:  r_cfg.high_thr  <= i_cfg_data[SAMPLE_W-1:0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/pgl_elem_mem.sv
// pgl_elem_mem: per-element level and gate store, one write and one registered read port
// depends on pgl_pkg; entry valid bits make unwritten entries read as zero
`timescale 1ns / 1ps
`default_nettype none

module pgl_elem_mem #(
    parameter int DEPTH = 144,
    parameter int IDX_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_idx,
    output pgl_pkg::t_elem        o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_idx,
    input  pgl_pkg::t_elem        i_wr_data
);
    import pgl_pkg::*;

    t_elem             r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    t_elem             r_rd_data;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
            end
        end
    end

    // never-written entries read as the reset state
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

### verif/tb_priority_gate_linearizer.sv
// tb_priority_gate_linearizer: self-checking bench for the priority gate linearizer
// depends on pgl_pkg, pgl_in_if, pgl_out_if and the priority_gate_linearizer top level
// directed elements first, then frames of random content under several settings and pacings
`timescale 1ns / 1ps

module tb_priority_gate_linearizer;
    import pgl_pkg::*;

    localparam int ROWS           = 9;
    localparam int CHANNELS       = 16;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 232;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTED    = 40;

    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // one trigger element as offered on the request channel
    typedef struct packed {
        logic                       frame_start;
        logic                       clock_connected;
        logic signed [SAMPLE_W-1:0] clock_sample;
        logic [ROW_W-1:0]           row;
        logic [CHAN_W-1:0]          channel;
        logic                       channel_new;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       mute_in;
        logic                       mute_out;
    } t_trig;

    typedef enum {CMP_NONE, CMP_RISE, CMP_FALL} t_cmp_event;

    // tracks the gate each request must produce and checks results in order
    class gate_scoreboard;
        logic [MODES_W-1:0]         row_modes;
        logic signed [SAMPLE_W-1:0] low_thr;
        logic signed [SAMPLE_W-1:0] high_thr;
        bit level_bits [ROWS*CHANNELS];
        bit gate_bits  [ROWS*CHANNELS];
        bit block_flag;
        bit clock_level;
        bit frame_enable;
        bit gates_due [$];
        int errors;
        int n_checked;

        function new();
            row_modes    = '0;
            low_thr      = LOW_THR_RST;
            high_thr     = HIGH_THR_RST;
            block_flag   = 1'b0;
            clock_level  = 1'b0;
            frame_enable = 1'b0;
            errors       = 0;
            n_checked    = 0;
            foreach (level_bits[i]) begin
                level_bits[i] = 1'b0;
                gate_bits[i]  = 1'b0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROW_MODES: row_modes = data[MODES_W-1:0];
                CFG_LOW_THR:   low_thr   = data[SAMPLE_W-1:0];
                CFG_HIGH_THR:  high_thr  = data[SAMPLE_W-1:0];
                default: ;
            endcase
        endfunction

        function t_cmp_event run_cmp(inout bit level, input logic signed [SAMPLE_W-1:0] x);
            if (level) begin
                if (x <= low_thr) begin
                    level = 1'b0;
                    return CMP_FALL;
                end
            end else if (x >= high_thr) begin
                level = 1'b1;
                return CMP_RISE;
            end
            return CMP_NONE;
        endfunction

        function int pending();
            return gates_due.size();
        endfunction

        function void note_element(t_trig r);
            int         idx;
            logic [1:0] mode;
            bit         g;
            bit         lv;
            t_cmp_event ev;
            if (r.frame_start) begin
                block_flag = 1'b0;
                if (!r.clock_connected)
                    frame_enable = 1'b1;
                else
                    frame_enable = (run_cmp(clock_level, r.clock_sample) == CMP_RISE);
            end
            if (r.row >= ROWS || r.channel >= CHANNELS) begin
                gates_due.push_back(1'b0);
                return;
            end
            idx  = r.row * CHANNELS + r.channel;
            mode = row_modes[2*r.row +: 2];
            if (r.channel_new) begin
                level_bits[idx] = 1'b0;
                gate_bits[idx]  = 1'b0;
            end
            g  = gate_bits[idx];
            lv = level_bits[idx];
            if (frame_enable) begin
                ev = run_cmp(lv, r.sample);
                if (ev == CMP_RISE) begin
                    g = (mode == MODE_ALL || mode == MODE_NEW_ALL || !block_flag) && !r.mute_in;
                    if (mode == MODE_NEW_ALL)
                        block_flag = g;
                    else if (mode != MODE_NB_LINEAR)
                        block_flag = block_flag || g;
                end else if (ev == CMP_FALL) begin
                    g = 1'b0;
                end
            end
            level_bits[idx] = lv;
            gate_bits[idx]  = g;
            gates_due.push_back(g && !r.mute_out);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_gate(logic gate);
            bit due;
            if (gates_due.size() == 0) begin
                report($sformatf("gate %b with no request waiting", gate));
            end else begin
                due = gates_due.pop_front();
                if (gate !== due)
                    report($sformatf("result %0d gate %b, want %b", n_checked, gate, due));
            end
            n_checked++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pgl_in_if  req_if ();
    pgl_out_if rsp_if ();

    priority_gate_linearizer #(
        .ROWS     (ROWS),
        .CHANNELS (CHANNELS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    gate_scoreboard sb = new();

    // pacing knobs, percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;
    bit holdoff_req = 1'b0;
    // clock input state carried from frame to frame
    bit clk_conn = 1'b1;
    bit clk_high = 1'b0;
    // active channels per row in the previous frame, drives channel_new
    int chan_active [ROWS];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // clamp to the 16-bit sample range
    function automatic logic signed [SAMPLE_W-1:0] sat16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[SAMPLE_W-1:0];
    endfunction

    // voltage near the thresholds most of the time, extremes and noise now and then
    function automatic logic signed [SAMPLE_W-1:0] pick_level(bit want_high);
        int lo;
        int hi;
        lo = int'(sb.low_thr);
        hi = int'(sb.high_thr);
        case ($urandom_range(11))
            0: return sb.high_thr;
            1: return sb.low_thr;
            2: return sat16(hi - 1);
            3: return sat16(lo + 1);
            4: return 16'sh7fff;
            5: return 16'sh8000;
            6: return SAMPLE_W'($urandom);
            default: begin
                if (want_high)
                    return sat16(hi + int'($urandom_range(2000)));
                return sat16(lo - int'($urandom_range(2000)));
            end
        endcase
    endfunction

    function automatic t_trig random_trig();
        t_trig r;
        r.frame_start     = 1'($urandom_range(1));
        r.clock_connected = 1'($urandom_range(1));
        r.clock_sample    = SAMPLE_W'($urandom);
        r.row             = ROW_W'($urandom_range(15));
        r.channel         = CHAN_W'($urandom_range(15));
        r.channel_new     = 1'($urandom_range(1));
        r.sample          = SAMPLE_W'($urandom);
        r.mute_in         = 1'($urandom_range(1));
        r.mute_out        = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic t_trig mk(bit fs, bit conn, int clk, int row, int ch, bit nw,
                                 int smp, bit mi, bit mo);
        t_trig r;
        r.frame_start     = fs;
        r.clock_connected = conn;
        r.clock_sample    = clk[SAMPLE_W-1:0];
        r.row             = row[ROW_W-1:0];
        r.channel         = ch[CHAN_W-1:0];
        r.channel_new     = nw;
        r.sample          = smp[SAMPLE_W-1:0];
        r.mute_in         = mi;
        r.mute_out        = mo;
        return r;
    endfunction

    // offer one request after a random gap, hold it until taken
    task automatic send_req(input t_trig r);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.frame_start     <= r.frame_start;
        req_if.clock_connected <= r.clock_connected;
        req_if.clock_sample    <= r.clock_sample;
        req_if.row             <= r.row;
        req_if.channel         <= r.channel;
        req_if.channel_new     <= r.channel_new;
        req_if.sample          <= r.sample;
        req_if.mute_in         <= r.mute_in;
        req_if.mute_out        <= r.mute_out;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        sb.note_element(r);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // registers change only with the pipeline empty; every request yields a result,
    // so an empty expectation queue means the block is idle
    task automatic apply_cfg(input logic [MODES_W-1:0] modes,
                             input logic signed [SAMPLE_W-1:0] lo,
                             input logic signed [SAMPLE_W-1:0] hi);
        logic [1:0] pad_lo;
        logic [1:0] pad_hi;
        pad_lo = 2'($urandom);
        pad_hi = 2'($urandom);
        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        cfg_write(CFG_ROW_MODES, modes);
        // bits above the threshold width must not matter
        cfg_write(CFG_LOW_THR, {pad_lo, lo});
        cfg_write(CFG_HIGH_THR, {pad_hi, hi});
        cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int pick_count();
        int k;
        k = $urandom_range(99);
        if (k < 60)
            return $urandom_range(2);
        if (k < 95)
            return $urandom_range(3, 6);
        return CHANNELS;
    endfunction

    // mostly whole frames in row order with random content, some broken frames,
    // some plain noise; out-of-range rows are not counted
    task automatic run_traffic(input int n_items);
        int    done_cnt;
        int    kind;
        int    n_noise;
        int    cnt [ROWS];
        int    total;
        bit    broken;
        bit    first;
        t_trig r;
        done_cnt = 0;
        while (done_cnt < n_items) begin
            kind = $urandom_range(99);
            if (kind >= 90) begin
                n_noise = $urandom_range(1, 4);
                repeat (n_noise) begin
                    r = random_trig();
                    send_req(r);
                    if (r.row < ROWS)
                        done_cnt++;
                end
            end else begin
                broken = (kind >= 80);
                total  = 0;
                foreach (cnt[rw]) begin
                    cnt[rw] = pick_count();
                    total  += cnt[rw];
                end
                if (total == 0)
                    cnt[0] = 1;
                if ($urandom_range(9) == 0)
                    clk_conn = !clk_conn;
                // clock mostly alternates so every other frame is enabled
                clk_high = ($urandom_range(4) == 0) ? bit'($urandom_range(1)) : !clk_high;
                first = 1'b1;
                for (int rw = 0; rw < ROWS; rw++) begin
                    for (int c = 0; c < cnt[rw]; c++) begin
                        r = random_trig();
                        r.frame_start = broken ? bit'($urandom_range(1)) : first;
                        if (first) begin
                            r.clock_connected = clk_conn;
                            r.clock_sample    = pick_level(clk_high);
                        end
                        r.row         = ROW_W'(rw);
                        r.channel     = CHAN_W'(c);
                        r.channel_new = broken ? bit'($urandom_range(1)) : (c >= chan_active[rw]);
                        if (broken && $urandom_range(7) == 0)
                            r.row = ROW_W'($urandom_range(ROWS, 15));
                        r.sample   = pick_level(bit'($urandom_range(1)));
                        r.mute_in  = ($urandom_range(99) < 15);
                        r.mute_out = ($urandom_range(99) < 15);
                        send_req(r);
                        if (r.row < ROWS)
                            done_cnt++;
                        first = 1'b0;
                    end
                    chan_active[rw] = cnt[rw];
                end
            end
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // every accepted result is checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_gate(rsp_if.gate);
    end

    // give up when nothing moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [MODES_W-1:0]         modes;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        int                         lo_i;
        logic [MODES_W-1:0]         mixed_modes;

        foreach (chan_active[rw])
            chan_active[rw] = 0;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = '0;
        i_cfg_data             = '0;
        req_if.valid           = 1'b0;
        req_if.frame_start     = 1'b0;
        req_if.clock_connected = 1'b0;
        req_if.clock_sample    = '0;
        req_if.row             = '0;
        req_if.channel         = '0;
        req_if.channel_new     = 1'b0;
        req_if.sample          = '0;
        req_if.mute_in         = 1'b0;
        req_if.mute_out        = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: every row linear, thresholds 0.1 V and 1 V
        send_req(mk(1, 0, 0,      0, 0, 1, 2048, 0, 0));   // no clock, rise exactly at high
        send_req(mk(0, 0, 0,      0, 1, 1, 32767, 0, 0));  // rise but blocked
        send_req(mk(0, 0, 0,      1, 0, 1, 2047, 0, 0));   // just under high, no event
        send_req(mk(0, 0, 0,      9, 0, 0, 32767, 0, 0));  // row out of range
        send_req(mk(0, 0, 0,      15, 15, 0, -32768, 1, 1));
        send_req(mk(1, 1, 2048,   0, 0, 0, 205, 0, 1));    // clock rises, element falls at low
        send_req(mk(1, 1, 2048,   0, 0, 0, 4000, 0, 0));   // clock still high, frame disabled
        send_req(mk(1, 1, 205,    0, 0, 0, 4000, 0, 0));   // clock falls, frame disabled
        send_req(mk(1, 1, 32767,  0, 0, 0, 4000, 1, 0));   // rise under input mute

        // one row per mode: linear, all, non-blocking linear, new all
        mixed_modes = MODES_W'({MODE_NEW_ALL, MODE_NB_LINEAR, MODE_ALL, MODE_LINEAR});
        apply_cfg(mixed_modes, LOW_THR_RST, HIGH_THR_RST);
        send_req(mk(1, 0, 0, 0, 3, 1, 3000, 0, 0));   // linear opens and blocks
        send_req(mk(0, 0, 0, 1, 3, 1, 3000, 0, 0));   // all ignores the block
        send_req(mk(0, 0, 0, 2, 3, 1, 3000, 0, 1));   // non-blocking linear blocked, out mute
        send_req(mk(0, 0, 0, 3, 3, 1, 3000, 1, 0));   // new all muted clears the block
        send_req(mk(0, 0, 0, 4, 3, 1, 3000, 0, 1));   // linear opens, output muted
        send_req(mk(1, 0, 0, 2, 4, 1, 3000, 0, 0));   // non-blocking linear leaves block clear
        send_req(mk(0, 0, 0, 3, 4, 1, 3000, 0, 0));   // new all opens and blocks
        send_req(mk(0, 0, 0, 8, 15, 1, 3000, 0, 0));  // last element blocked
        send_req(mk(1, 0, 0, 8, 15, 0, 32767, 0, 0)); // already high, no event
        send_req(mk(1, 0, 0, 0, 3, 0, 100, 0, 0));    // fall closes the gate
        send_req(mk(0, 0, 0, 1, 3, 1, 100, 0, 0));   // new channel drops a stored open gate

        // thresholds swapped
        apply_cfg(mixed_modes, 16'sd3000, 16'sd1000);
        send_req(mk(1, 0, 0, 5, 0, 1, 1000, 0, 0));
        send_req(mk(0, 0, 0, 5, 0, 0, 2999, 0, 0));

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin
                    modes = '0;
                    lo    = LOW_THR_RST;
                    hi    = HIGH_THR_RST;
                end
                1: begin
                    modes = '1;
                    lo    = 16'sh8000;
                    hi    = 16'sh7fff;
                end
                2: begin
                    modes = 18'h2AAAA;
                    lo    = HIGH_THR_RST;
                    hi    = LOW_THR_RST;
                end
                4: begin
                    modes = 18'h15555;
                    lo    = '0;
                    hi    = '0;
                end
                5: begin
                    // swapped extremes: every visit toggles the comparator
                    modes = '1;
                    lo    = 16'sh7fff;
                    hi    = 16'sh8000;
                end
                7: begin
                    modes = MODES_W'($urandom);
                    lo    = SAMPLE_W'($urandom);
                    hi    = SAMPLE_W'($urandom);
                end
                default: begin
                    modes = MODES_W'($urandom);
                    lo_i  = int'($urandom_range(2000)) - 1000;
                    lo    = lo_i[SAMPLE_W-1:0];
                    hi    = sat16(lo_i + int'($urandom_range(3000)));
                end
            endcase
            apply_cfg(modes, lo, hi);
            case (p % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 83;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 83;
                end
                default: begin
                    idle_pct  = 34;
                    stall_pct = 34;
                end
            endcase
            // long receiver hold-off while requests keep coming, fills the pipeline
            if (p == 0)
                holdoff_req = 1'b1;
            run_traffic(PHASE_ITEMS);
        end

        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        // any stray result after the last expected one still gets flagged
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
